@@ src/indexed_double_ended_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the indexed deque.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define IDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/idq_pkg.sv @@
// ----------------------------------------------------------------------------
// idq_pkg
// Command, status and cell-operation codes and the result word layout.
// ----------------------------------------------------------------------------
package idq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } cell_op_t;

  localparam int unsigned RD_W  = 32;
  localparam int unsigned CNT_OUT_W = 7;

  typedef struct packed {
    status_t                status;
    logic [CNT_OUT_W-1:0]   element_count;
    logic [RD_W-1:0]        read_data;
  } result_t;

endpackage

@@ src/idq_cell.sv @@
// ----------------------------------------------------------------------------
// idq_cell
// One storage cell of the shift chain: holds the element at its own logical
// index and takes its left or right neighbour on insert or erase.
// ----------------------------------------------------------------------------
module idq_cell import idq_pkg::*; #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned IDX_W  = 6
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_index,
  input  cell_op_t          op,
  input  logic [IDX_W-1:0]  idx,
  input  logic [DATA_W-1:0] word_in,
  input  logic [DATA_W-1:0] left_word,
  input  logic [DATA_W-1:0] right_word,
  input  logic              rd_en,
  output logic [DATA_W-1:0] word,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (op)
      OP_OPEN: begin
        if (cell_index > idx) begin
          word_next = left_word;
        end else if (cell_index == idx) begin
          word_next = word_in;
        end
      end
      OP_CLOSE: begin
        if (cell_index >= idx) begin
          word_next = right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign tap = (rd_en && (cell_index == idx)) ? word : '0;

endmodule

@@ src/idq_ctrl.sv @@
// ----------------------------------------------------------------------------
// idq_ctrl
// Command decode, bounds checks and element count; drives the chain control.
// ----------------------------------------------------------------------------
module idq_ctrl import idq_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cmd_t             cmd,
  input  logic [6:0]       position,
  output cell_op_t         op,
  output logic [IDX_W-1:0] idx,
  output logic             rd_en,
  output status_t          status,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] count_next
);

  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             empty;
  cell_op_t         op_raw;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    op_raw     = OP_HOLD;
    idx        = '0;
    rd_en      = 1'b0;
    status     = ST_OK;
    count_next = count;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op_raw     = OP_OPEN;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op_raw     = OP_OPEN;
          idx        = IDX_W'(count);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          op_raw     = OP_CLOSE;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op_raw     = OP_OPEN;
          idx        = IDX_W'(position);
          count_next = count + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          op_raw     = OP_CLOSE;
          idx        = IDX_W'(position);
          count_next = count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_en = 1'b1;
          idx   = IDX_W'(position);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        op_raw = OP_HOLD;
      end
    endcase
  end

  assign op = accept ? op_raw : OP_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

@@ src/indexed_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// indexed_double_ended_queue
// Bounded deque of DEPTH words held in a chain of cells; push, pop, insert,
// erase and read at a logical index, and clear.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                         tuser
// s_       in   position[6:0], value[38:7], pad[39]        cmd[2:0]
// m_       out  read_data[31:0], element_count[38:32], pad  status[1:0]
//
// Every command completes in the cycle it is accepted: one word per cycle while s_tready is high.
// Insert and erase shift all later cells by one in that same cycle.
// Reset clears the element count; cell contents stay undefined until written.
// A two-word output buffer lets one word be accepted while a result waits;
// s_tready drops only when both output slots are full.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue import idq_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero[39]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data[31:0], element_count[38:32], zero[39]
  output logic [1:0]  m_tuser    // status[1:0]
);

  `include "indexed_double_ended_queue_macros.svh"

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic              accept;
  logic              take;
  cell_op_t          op;
  logic [IDX_W-1:0]  idx;
  logic              rd_en;
  status_t           status;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] word_in;
  logic [DATA_W-1:0] cell_word [DEPTH];
  logic [DATA_W-1:0] cell_tap  [DEPTH];
  logic [DATA_W-1:0] rd_word;
  result_t           res;
  result_t           main_word;
  result_t           skid_word;
  logic              out_valid;
  logic              skid_valid;

  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;
  assign s_tready = !skid_valid;
  assign word_in  = DATA_W'(s_tdata[38:7]);

  idq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd_t'(s_tuser)),
    .position   (s_tdata[6:0]),
    .op         (op),
    .idx        (idx),
    .rd_en      (rd_en),
    .status     (status),
    .count      (count),
    .count_next (count_next)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_word;
    logic [DATA_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_left
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_right
      assign right_word = cell_word[i+1];
    end

    idq_cell #(
      .DATA_W (DATA_W),
      .IDX_W  (IDX_W)
    ) u_cell (
      .clk        (clk),
      .cell_index (IDX_W'(i)),
      .op         (op),
      .idx        (idx),
      .word_in    (word_in),
      .left_word  (left_word),
      .right_word (right_word),
      .rd_en      (rd_en),
      .word       (cell_word[i]),
      .tap        (cell_tap[i])
    );
  end

  // at most one tap is non-zero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  assign res.status        = status;
  assign res.element_count = CNT_OUT_W'(count_next);
  assign res.read_data     = RD_W'(rd_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !take) begin
        skid_word <= res;
      end else begin
        main_word <= res;
      end
    end else if (take && skid_valid) begin
      main_word <= skid_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, main_word.element_count, main_word.read_data};
  assign m_tuser  = main_word.status;

  `IDQ_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "element count above depth")
  `IDQ_ASSERT_IMPL(a_skid_order, skid_valid, out_valid, "skid word without main word")
  `IDQ_ASSERT_IMPL(a_full_status, accept && (status == ST_FULL), count == CNT_W'(DEPTH),
    "full status with free space")
  `IDQ_ASSERT_NEXT(a_skid_fill, accept && out_valid && !take, skid_valid,
    "stalled result not held in skid")

endmodule

@@ test/indexed_double_ended_queue_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_test
// Self-checking bench for the indexed deque. A short directed table walks the
// empty, end and out-of-range cases. Random runs then grow, shrink and mix
// the store so that it fills and drains many times. Results are checked
// against a cycle-free bench copy of the deque, or for fixed directed rows
// against the typed-in word. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_test import idq_pkg::*;;

  localparam int DEPTH        = 64;
  localparam int RANDOM_WORDS = 1300;
  localparam int PHASES       = 5;

  typedef struct {
    cmd_t        cmd;
    logic [6:0]  pos;
    logic [31:0] value;
    bit          fixed;   // expected word typed in below
    result_t     res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = CMD_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // bench copy of the deque
  logic [31:0] deque_cells [DEPTH];
  int          deque_len;
  result_t     pending_results [$];

  int unsigned send_gap_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int          mismatch_count = 0;

  dir_row_t directed_rows [25] = '{
    '{CMD_POP_FRONT,  7'd0,  32'h0,        1'b1, '{ST_RANGE, 7'd0, 32'h0}},
    '{CMD_POP_BACK,   7'd0,  32'h0,        1'b1, '{ST_RANGE, 7'd0, 32'h0}},
    '{CMD_READ,       7'd0,  32'h0,        1'b1, '{ST_RANGE, 7'd0, 32'h0}},
    '{CMD_ERASE,      7'd0,  32'h0,        1'b1, '{ST_RANGE, 7'd0, 32'h0}},
    '{CMD_INSERT,     7'd1,  32'h1,        1'b1, '{ST_RANGE, 7'd0, 32'h0}},
    '{CMD_CLEAR,      7'd0,  32'h0,        1'b1, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_PUSH_BACK,  7'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,    7'd1, 32'h0}},
    '{CMD_PUSH_FRONT, 7'd0,  32'h0,        1'b1, '{ST_OK,    7'd2, 32'h0}},
    '{CMD_READ,       7'd0,  32'h0,        1'b1, '{ST_OK,    7'd2, 32'h0}},
    '{CMD_READ,       7'd1,  32'h0,        1'b1, '{ST_OK,    7'd2, 32'hFFFFFFFF}},
    '{CMD_READ,       7'd2,  32'h0,        1'b1, '{ST_RANGE, 7'd2, 32'h0}},
    '{CMD_INSERT,     7'd2,  32'hA5A5A5A5, 1'b1, '{ST_OK,    7'd3, 32'h0}},
    '{CMD_INSERT,     7'd0,  32'h5A5A5A5A, 1'b1, '{ST_OK,    7'd4, 32'h0}},
    '{CMD_INSERT,     7'd2,  32'h12345678, 1'b1, '{ST_OK,    7'd5, 32'h0}},
    '{CMD_READ,       7'd2,  32'h0,        1'b1, '{ST_OK,    7'd5, 32'h12345678}},
    '{CMD_ERASE,      7'd4,  32'h0,        1'b1, '{ST_OK,    7'd4, 32'h0}},
    '{CMD_ERASE,      7'd0,  32'h0,        1'b1, '{ST_OK,    7'd3, 32'h0}},
    '{CMD_READ,       7'd64, 32'h0,        1'b1, '{ST_RANGE, 7'd3, 32'h0}},
    '{CMD_INSERT,     7'd64, 32'hDEADBEEF, 1'b1, '{ST_RANGE, 7'd3, 32'h0}},
    '{CMD_ERASE,      7'd1,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_READ,       7'd0,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_READ,       7'd1,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_POP_BACK,   7'd0,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_POP_FRONT,  7'd0,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}},
    '{CMD_READ,       7'd0,  32'h0,        1'b0, '{ST_OK,    7'd0, 32'h0}}
  };

  indexed_double_ended_queue #(
    .DEPTH  (DEPTH),
    .DATA_W (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one command to the bench deque and return the word it should produce.
  function automatic result_t deque_apply(cmd_t cmd, int pos, logic [31:0] value);
    result_t r;
    int      at;
    r.read_data = '0;
    r.status    = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        at = (cmd == CMD_PUSH_FRONT) ? 0 : (cmd == CMD_PUSH_BACK) ? deque_len : pos;
        if (cmd == CMD_INSERT && pos > deque_len) begin
          r.status = ST_RANGE;
        end else if (deque_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = deque_len; i > at; i--) deque_cells[i] = deque_cells[i-1];
          deque_cells[at] = value;
          deque_len++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
        at = (cmd == CMD_POP_FRONT) ? 0 : (cmd == CMD_POP_BACK) ? deque_len - 1 : pos;
        if (at < 0 || at >= deque_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = at; i + 1 < deque_len; i++) deque_cells[i] = deque_cells[i+1];
          deque_len--;
        end
      end
      CMD_READ: begin
        if (pos >= deque_len) r.status = ST_RANGE;
        else r.read_data = deque_cells[pos];
      end
      default: deque_len = 0;
    endcase
    r.element_count = deque_len[6:0];
    return r;
  endfunction

  // Drive one word from a falling edge; returns at the falling edge after it is taken.
  task automatic send_word(cmd_t cmd, logic [6:0] pos, logic [31:0] value,
                           bit fixed, result_t fixed_res);
    result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, value, pos};
    s_tuser  = cmd;
    do @(posedge clk); while (!s_tready);
    r = deque_apply(cmd, pos, value);
    pending_results.push_back(fixed ? fixed_res : r);
    @(negedge clk);
  endtask

  function automatic cmd_t pick_cmd(int trend);
    int unsigned grow_pct;
    int unsigned r;
    int unsigned k;
    grow_pct = (trend == 0) ? 85 : (trend == 1) ? 20 : 50;
    r = $urandom_range(99);
    k = $urandom_range(2);
    if (trend != 0 && r < 2) return CMD_CLEAR;
    if (r < 14) return CMD_READ;
    if ($urandom_range(99) < grow_pct)
      return (k == 0) ? CMD_PUSH_FRONT : (k == 1) ? CMD_PUSH_BACK : CMD_INSERT;
    return (k == 0) ? CMD_POP_FRONT : (k == 1) ? CMD_POP_BACK : CMD_ERASE;
  endfunction

  function automatic logic [6:0] pick_pos(cmd_t cmd);
    int unsigned r;
    int          top;
    r   = $urandom_range(99);
    top = (cmd == CMD_INSERT) ? deque_len : deque_len - 1;
    if (top < 0) top = 0;
    if (r < 70) return 7'($urandom_range(top));
    if (r < 85) begin
      case ($urandom_range(2))
        0: return 7'd0;
        1: return 7'(deque_len);
        default: return 7'(top);
      endcase
    end
    return 7'($urandom_range(64));
  endfunction

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word tdata=%h tuser=%h", $time, m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[38:32] !== want.element_count) begin
          $display("%0t: element_count expected %0d actual %0d", $time,
                   want.element_count, m_tdata[38:32]);
          mismatch_count++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int   trend;
    int   run_left;
    cmd_t cmd;
    for (int i = 0; i < DEPTH; i++) deque_cells[i] = '0;
    deque_len = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                directed_rows[i].fixed, directed_rows[i].res);

    trend    = 0;
    run_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      // hold off until the block has drained
      s_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      case (ph)
        1: begin send_gap_pct = 84; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 84; end
        3: begin send_gap_pct = 26; sink_stall_pct = 26; end
        default: begin send_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        if (run_left == 0) begin
          trend    = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 2);
          run_left = $urandom_range(30, 90);
        end
        run_left--;
        cmd = pick_cmd(trend);
        send_word(cmd, pick_pos(cmd), $urandom, 1'b0, '{ST_OK, 7'd0, 32'h0});
      end
    end
    s_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_double_ended_queue verification clean");
    end else begin
      $display("indexed_double_ended_queue verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("indexed_double_ended_queue verification failed");
    $finish;
  end

endmodule
